FILE: hw/rtl/lbsa_pkg.sv
// Shared types and constants for the least-busy slot allocator.
package lbsa_pkg;

  // Default storage sizes
  localparam int unsigned MaxWorkersDef = 8;
  localparam int unsigned MaxSlotsDef   = 16;

  // Fixed field widths
  localparam int unsigned ActW   = 4;
  localparam int unsigned SpwW   = 5;
  localparam int unsigned CfgW   = 5;
  localparam int unsigned WorkW  = 3;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CntOutW = 5;

  // Configuration register indexes
  typedef enum logic {
    CFG_ACTIVE_WORKERS   = 1'b0,
    CFG_SLOTS_PER_WORKER = 1'b1
  } cfg_idx_e;

  // Request kinds
  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_GRANTED  = 2'd0,
    STAT_RELEASED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_FREE_REL = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK_RD,
    S_PICK,
    S_REL_RD,
    S_REL,
    S_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch request fields, restart scan
    logic scan;      // issue scan read, evaluate previous candidate
    logic rd_best;   // read the chosen worker
    logic set_full;  // record an all-full result
    logic pick;      // grant lowest free slot of chosen worker
    logic rd_rel;    // read the worker named by a release
    logic rel;       // apply the release
    logic load_out;  // move result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/lbsa_ctrl.sv
// Request sequencer for the least-busy slot allocator.
module lbsa_ctrl import lbsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_kind_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == KIND_RELEASE) ? S_REL_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_PICK_RD;
      end
      S_PICK_RD: begin
        state_d = stat_i.found ? S_PICK : S_DONE;
      end
      S_PICK:   state_d = S_DONE;
      S_REL_RD: state_d = S_REL;
      S_REL:    state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_SCAN:    cmd_o.scan = 1'b1;
      S_PICK_RD: begin
        cmd_o.rd_best  = stat_i.found;
        cmd_o.set_full = !stat_i.found;
      end
      S_PICK:    cmd_o.pick   = 1'b1;
      S_REL_RD:  cmd_o.rd_rel = 1'b1;
      S_REL:     cmd_o.rel    = 1'b1;
      S_DONE:    cmd_o.load_out = stat_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  // A transfer in idle always starts work
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("request transfer did not leave idle");

  // Only one storage-changing command at a time
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.pick, cmd_o.rel, cmd_o.set_full, cmd_o.scan}))
    else $error("conflicting datapath commands");

  // Results are handed over only from the final state
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (state_q == S_IDLE))
    else $error("output load did not return to idle");

endmodule

FILE: hw/rtl/lbsa_dp.sv
// Worker table, least-busy scan, slot grant/release and output register.
module lbsa_dp import lbsa_pkg::*; #(
  parameter int unsigned MAX_WORKERS = MaxWorkersDef,
  parameter int unsigned MAX_SLOTS   = MaxSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic [WorkW-1:0]  in_release_worker_i,
  input  logic [SlotW-1:0]  in_release_slot_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        out_status_o,
  output logic [WorkW-1:0]  out_granted_worker_o,
  output logic [SlotW-1:0]  out_granted_slot_o,
  output logic [CntOutW-1:0] out_worker_busy_count_o,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o
);

  localparam int unsigned WIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned WCW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned SIW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EW  = 7;  // holds any index or limit up to 64
  localparam int unsigned MW  = CW + MAX_SLOTS;

  // Configuration registers
  logic [ActW-1:0] act_q;
  logic [SpwW-1:0] spw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ActW'(8);
      spw_q <= SpwW'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_WORKERS:   act_q <= cfg_data_i[ActW-1:0];
        CFG_SLOTS_PER_WORKER: spw_q <= cfg_data_i;
        default:              act_q <= act_q;
      endcase
    end
  end

  // Clamped limits and slot window
  logic [WCW-1:0]       nw;
  logic [EW-1:0]        sc;
  logic [MAX_SLOTS-1:0] window;

  always_comb begin
    if (act_q == '0) begin
      nw = WCW'(1);
    end else if (EW'(act_q) > EW'(MAX_WORKERS)) begin
      nw = WCW'(MAX_WORKERS);
    end else begin
      nw = WCW'(act_q);
    end
    if (spw_q == '0) begin
      sc = EW'(1);
    end else if (EW'(spw_q) > EW'(MAX_SLOTS)) begin
      sc = EW'(MAX_SLOTS);
    end else begin
      sc = EW'(spw_q);
    end
    for (int j = 0; j < MAX_SLOTS; j++) begin
      window[j] = EW'(j) < sc;
    end
  end

  // Latched request fields
  logic [WorkW-1:0] rel_worker_q;
  logic [SlotW-1:0] rel_slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rel_worker_q <= in_release_worker_i;
      rel_slot_q   <= in_release_slot_i;
    end
  end

  logic [EW-1:0]  rw_ext;
  logic [EW-1:0]  rs_ext;
  logic [WIW-1:0] rw_idx;
  logic           rw_ok;

  assign rw_ext = EW'(rel_worker_q);
  assign rs_ext = EW'(rel_slot_q);
  assign rw_idx = rw_ext[WIW-1:0];
  assign rw_ok  = rw_ext < EW'(MAX_WORKERS);

  // Scan counter
  logic [WCW-1:0] scan_cnt_q;
  logic           scan_issue;

  assign scan_issue = cmd_i.scan && (scan_cnt_q < nw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.capture) begin
      scan_cnt_q <= '0;
    end else if (scan_issue) begin
      scan_cnt_q <= scan_cnt_q + WCW'(1);
    end
  end

  // Worker table: {count, mask} per worker, one read and one write port
  logic [MW-1:0]          mem_q [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] vld_q;
  logic [MW-1:0]          rd_word_q;
  logic                   rd_vld_q;
  logic                   rd_en;
  logic [WIW-1:0]         rd_addr;
  logic                   wr_en;
  logic [WIW-1:0]         wr_addr;
  logic [MW-1:0]          wr_data;
  logic [WIW-1:0]         best_idx_q;

  always_comb begin
    if (cmd_i.scan) begin
      rd_addr = scan_cnt_q[WIW-1:0];
    end else if (cmd_i.rd_best) begin
      rd_addr = best_idx_q;
    end else begin
      rd_addr = rw_idx;
    end
    rd_en = scan_issue || cmd_i.rd_best || (cmd_i.rd_rel && rw_ok);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_word_q <= mem_q[rd_addr];
  end

  // Entry valid bits: an unwritten worker reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_q <= vld_q[rd_addr];
    end
  end

  logic [MAX_SLOTS-1:0] rd_mask;
  logic [CW-1:0]        rd_cnt;

  assign rd_mask = rd_vld_q ? rd_word_q[MAX_SLOTS-1:0] : '0;
  assign rd_cnt  = rd_vld_q ? rd_word_q[MW-1:MAX_SLOTS] : '0;

  // Candidate evaluation, one worker per cycle behind the read
  logic           eval_v_q;
  logic [WIW-1:0] eval_idx_q;
  logic           best_found_q;
  logic [CW-1:0]  best_cnt_q;
  logic           cand;

  assign cand = cmd_i.scan && eval_v_q && (|(~rd_mask & window)) &&
                (!best_found_q || (rd_cnt < best_cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_v_q     <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      eval_v_q <= scan_issue;
      if (cmd_i.capture) begin
        best_found_q <= 1'b0;
      end else if (cand) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= scan_cnt_q[WIW-1:0];
    if (cand) begin
      best_cnt_q <= rd_cnt;
      best_idx_q <= eval_idx_q;
    end
  end

  // Lowest free slot of the chosen worker
  logic [MAX_SLOTS-1:0] free_bits;
  logic [MAX_SLOTS-1:0] free_low;
  logic [SIW-1:0]       free_idx;

  always_comb begin
    free_bits = ~rd_mask & window;
    free_low  = free_bits & (~free_bits + MAX_SLOTS'(1));
    free_idx  = '0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if (free_low[j]) free_idx = free_idx | SIW'(j);
    end
  end

  // Release decode
  logic [MAX_SLOTS-1:0] rel_bit;
  logic                 rel_hit;

  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      rel_bit[j] = rs_ext == EW'(j);
    end
    rel_hit = rw_ok && (|(rel_bit & rd_mask));
  end

  // Table write
  always_comb begin
    wr_en   = cmd_i.pick || (cmd_i.rel && rel_hit);
    wr_addr = cmd_i.pick ? best_idx_q : rw_idx;
    if (cmd_i.pick) begin
      wr_data = {rd_cnt + CW'(1), rd_mask | free_low};
    end else begin
      wr_data = {rd_cnt - CW'(1), rd_mask & ~rel_bit};
    end
  end

  // Result register
  status_e            res_status_q;
  logic [WorkW-1:0]   res_worker_q;
  logic [SlotW-1:0]   res_slot_q;
  logic [CntOutW-1:0] res_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_full) begin
      res_status_q <= STAT_FULL;
      res_worker_q <= '0;
      res_slot_q   <= '0;
      res_cnt_q    <= '0;
    end else if (cmd_i.pick) begin
      res_status_q <= STAT_GRANTED;
      res_worker_q <= WorkW'(best_idx_q);
      res_slot_q   <= SlotW'(free_idx);
      res_cnt_q    <= CntOutW'(rd_cnt + CW'(1));
    end else if (cmd_i.rel) begin
      res_status_q <= rel_hit ? STAT_RELEASED : STAT_FREE_REL;
      res_worker_q <= rel_worker_q;
      res_slot_q   <= rel_slot_q;
      if (!rw_ok) begin
        res_cnt_q <= '0;
      end else if (rel_hit) begin
        res_cnt_q <= CntOutW'(rd_cnt - CW'(1));
      end else begin
        res_cnt_q <= CntOutW'(rd_cnt);
      end
    end
  end

  // Output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [WorkW-1:0]   out_worker_q;
  logic [SlotW-1:0]   out_slot_q;
  logic [CntOutW-1:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_worker_q <= res_worker_q;
      out_slot_q   <= res_slot_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_status_o            = out_status_q;
  assign out_granted_worker_o    = out_worker_q;
  assign out_granted_slot_o      = out_slot_q;
  assign out_worker_busy_count_o = out_cnt_q;

  // Status to controller
  assign stat_o.scan_done = scan_cnt_q == nw;
  assign stat_o.found     = best_found_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // A grant only happens after a worker with room was found
  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> best_found_q)
    else $error("grant without a candidate worker");

  // A granted worker always ends with at least one busy slot
  a_grant_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |=> (res_status_q == STAT_GRANTED && res_cnt_q != '0))
    else $error("granted result with zero busy count");

  // A granted slot lies inside the window and was free
  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> $onehot(free_low))
    else $error("no free slot in chosen worker");

endmodule

FILE: hw/rtl/least_busy_slot_allocator.sv
// Top level of the least-busy slot allocator: sequencer plus datapath.
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_we_i             cfg_idx_i, cfg_data_i
//  in       in         in_valid_i/stall_o   kind, release_worker, release_slot
//  out      out        out_valid_o/stall_i  status, granted_worker/slot, busy count
//
// Allocate: the scan reads one worker table entry per cycle over nw workers
//   (nw = clamped active_workers), then the chosen worker is read and its
//   lowest free slot is granted; when every slot is full no grant is made.
// Release: the named worker is read, then the named slot is freed.
// One request at a time; a new request is taken in the cycle after the result
//   is loaded, while that result may still wait in the output register.
// Reset: all slots free, active_workers 8, slots_per_worker 16; no sweep.
// out_stall_i holds the result in place; the sequencer waits for room.
module least_busy_slot_allocator import lbsa_pkg::*; #(
  parameter int unsigned MAX_WORKERS = MaxWorkersDef,
  parameter int unsigned MAX_SLOTS   = MaxSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [WorkW-1:0]   release_worker_i,
  input  logic [SlotW-1:0]   release_slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [WorkW-1:0]   granted_worker_o,
  output logic [SlotW-1:0]   granted_slot_o,
  output logic [CntOutW-1:0] worker_busy_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (kind_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lbsa_dp #(
    .MAX_WORKERS (MAX_WORKERS),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .in_release_worker_i     (release_worker_i),
    .in_release_slot_i       (release_slot_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_status_o            (status_o),
    .out_granted_worker_o    (granted_worker_o),
    .out_granted_slot_o      (granted_slot_o),
    .out_worker_busy_count_o (worker_busy_count_o),
    .cmd_i                   (cmd),
    .stat_o                  (stat)
  );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the least-busy slot allocator.
module tb;
  import lbsa_pkg::*;

  localparam int unsigned NW = MaxWorkersDef;
  localparam int unsigned NS = MaxSlotsDef;
  localparam int unsigned SETTLE_CYCLES = 16;    // above the longest allocate latency
  localparam int unsigned STUCK_LIMIT = 2000;    // cycles without any transfer
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 140;

  typedef struct packed {
    kind_e              kind;
    logic [WorkW-1:0]   worker;
    logic [SlotW-1:0]   slot;
  } slot_req_t;

  typedef struct packed {
    status_e            status;
    logic [WorkW-1:0]   worker;
    logic [SlotW-1:0]   slot;
    logic [CntOutW-1:0] count;
  } slot_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = 1'b0;
  logic [WorkW-1:0]   release_worker_i = '0;
  logic [SlotW-1:0]   release_slot_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [WorkW-1:0]   granted_worker_o;
  logic [SlotW-1:0]   granted_slot_o;
  logic [CntOutW-1:0] worker_busy_count_o;

  least_busy_slot_allocator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .release_worker_i   (release_worker_i),
    .release_slot_i     (release_slot_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .granted_worker_o   (granted_worker_o),
    .granted_slot_o     (granted_slot_o),
    .worker_busy_count_o(worker_busy_count_o)
  );

  // Shadow of the allocator state and registers
  logic [NS-1:0]      busy_mask [NW];
  logic [CntOutW-1:0] busy_count [NW];
  logic [ActW-1:0]    act_reg = ActW'(8);
  logic [SpwW-1:0]    spw_reg = SpwW'(16);

  slot_req_t    pending_reqs [$];
  slot_result_t awaited_results [$];

  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  int unsigned n_granted = 0, n_released = 0, n_full = 0, n_free_rel = 0;
  int unsigned n_settings = 1;
  bit          in_quiet = 1'b0, out_quiet = 1'b0;
  int unsigned in_gap = 0, out_hold = 0;

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Least-loaded pick with lowest free slot, or release of the named slot
  function automatic void predict_slot_result(input kind_e kind,
                                              input logic [WorkW-1:0] rw,
                                              input logic [SlotW-1:0] rs);
    slot_result_t r;
    int unsigned  nw, spw, w, s;
    logic [NS-1:0] window;
    bit           found;
    r.status = STAT_FULL;
    r.worker = '0;
    r.slot   = '0;
    r.count  = '0;
    if (kind == KIND_ALLOC) begin
      nw  = (act_reg == 0) ? 1 : (act_reg > NW) ? NW : act_reg;
      spw = (spw_reg == 0) ? 1 : (spw_reg > NS) ? NS : spw_reg;
      for (s = 0; s < NS; s++) window[s] = (s < spw);
      found = 1'b0;
      for (w = 0; w < nw; w++) begin
        if ((~busy_mask[w] & window) != '0 &&
            (!found || busy_count[w] < busy_count[r.worker])) begin
          found = 1'b1;
          r.worker = WorkW'(w);
        end
      end
      if (found) begin
        s = 0;
        while (busy_mask[r.worker][s] || !window[s]) s++;
        busy_mask[r.worker][s] = 1'b1;
        busy_count[r.worker] = busy_count[r.worker] + CntOutW'(1);
        r.status = STAT_GRANTED;
        r.slot   = SlotW'(s);
        r.count  = busy_count[r.worker];
      end
    end else begin
      r.worker = rw;
      r.slot   = rs;
      if (busy_mask[rw][rs]) begin
        busy_mask[rw][rs] = 1'b0;
        busy_count[rw] = busy_count[rw] - CntOutW'(1);
        r.status = STAT_RELEASED;
      end else begin
        r.status = STAT_FREE_REL;
      end
      r.count = busy_count[rw];
    end
    awaited_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [4:0] exp_v,
                                      input logic [4:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    slot_req_t req;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_gap != 0 || pending_reqs.size() == 0) begin
        if (in_gap != 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        req = pending_reqs.pop_front();
        in_valid_i       <= 1'b1;
        kind_i           <= req.kind;
        release_worker_i <= req.worker;
        release_slot_i   <= req.slot;
        in_gap = idle_len(in_quiet);
        if ($urandom_range(0, 47) == 0) in_quiet = !in_quiet;
      end
    end
  end

  // Result back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_hold != 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_hold = idle_len(out_quiet);
        if ($urandom_range(0, 47) == 0) out_quiet = !out_quiet;
      end
    end
  end

  // Monitor: predict on request transfer, check on result transfer, watchdog
  always @(posedge clk_i) begin
    slot_result_t exp_r;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        predict_slot_result(kind_e'(kind_i), release_worker_i, release_slot_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: status %0d worker %0d slot %0d count %0d",
                 status_o, granted_worker_o, granted_slot_o, worker_busy_count_o);
          mismatches++;
        end else begin
          exp_r = awaited_results.pop_front();
          check_field("status", CntOutW'(exp_r.status), CntOutW'(status_o));
          check_field("granted_worker", CntOutW'(exp_r.worker),
                      CntOutW'(granted_worker_o));
          check_field("granted_slot", CntOutW'(exp_r.slot), CntOutW'(granted_slot_o));
          check_field("worker_busy_count", exp_r.count, worker_busy_count_o);
        end
        case (status_o)
          STAT_GRANTED:  n_granted++;
          STAT_RELEASED: n_released++;
          STAT_FULL:     n_full++;
          default:       n_free_rel++;
        endcase
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 stuck_cycles, awaited_results.size());
        $display("** least_busy_slot_allocator: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_req(input kind_e kind, input int unsigned w, input int unsigned s);
    slot_req_t req;
    req.kind   = kind;
    req.worker = WorkW'(w);
    req.slot   = SlotW'(s);
    pending_reqs.push_back(req);
  endtask

  // Wait until every request is answered, then let the block settle
  task automatic drain_and_settle();
    while (pending_reqs.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ACTIVE_WORKERS) act_reg = val[ActW-1:0];
    else spw_reg = val[SpwW-1:0];
  endtask

  // Random request: releases mostly target a slot that is busy right now
  task automatic push_random_req(input int unsigned alloc_pct);
    int unsigned total, pick, w, s;
    bit          hit;
    w = $urandom_range(0, NW - 1);
    s = $urandom_range(0, NS - 1);
    if ($urandom_range(0, 99) < alloc_pct) begin
      push_req(KIND_ALLOC, w, s);
    end else begin
      total = 0;
      for (w = 0; w < NW; w++) total += busy_count[w];
      if (total != 0 && $urandom_range(0, 99) < 75) begin
        pick = $urandom_range(0, total - 1);
        hit = 1'b0;
        for (w = 0; w < NW && !hit; w++) begin
          for (s = 0; s < NS && !hit; s++) begin
            if (busy_mask[w][s]) begin
              if (pick == 0) begin
                push_req(KIND_RELEASE, w, s);
                hit = 1'b1;
              end else begin
                pick--;
              end
            end
          end
        end
      end else begin
        push_req(KIND_RELEASE, w, s);
      end
    end
  endtask

  // Stimulus
  initial begin
    int unsigned p, i, w, alloc_pct;
    int unsigned act_tab [6];
    int unsigned spw_tab [6];
    int unsigned pct_tab [4];
    act_tab = '{1, 8, 15, 0, 2, 8};
    spw_tab = '{16, 1, 31, 0, 5, 16};
    pct_tab = '{85, 50, 30, 70};
    for (w = 0; w < NW; w++) begin
      busy_mask[w]  = '0;
      busy_count[w] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ties go low, lowest free slot, releases of busy and free slots
    for (i = 0; i < 9; i++) push_req(KIND_ALLOC, NW - 1, NS - 1);
    push_req(KIND_RELEASE, NW - 1, NS - 1);
    push_req(KIND_RELEASE, 0, 0);
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_RELEASE, 0, 0);
    push_req(KIND_RELEASE, 0, 0);
    push_req(KIND_RELEASE, 3, 0);
    push_req(KIND_ALLOC, 5, 9);
    drain_and_settle();

    // Zero in both registers clamps to one worker with one slot: all full,
    // and releases of busy slots beyond the limits
    write_reg(CFG_ACTIVE_WORKERS, '0);
    write_reg(CFG_SLOTS_PER_WORKER, '0);
    n_settings++;
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_RELEASE, 5, 0);
    push_req(KIND_RELEASE, 0, 1);
    push_req(KIND_ALLOC, 0, 0);
    drain_and_settle();

    // Oversized values clamp to the top
    write_reg(CFG_ACTIVE_WORKERS, 5'd15);
    write_reg(CFG_SLOTS_PER_WORKER, 5'd31);
    n_settings++;
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_RELEASE, 7, 0);
    drain_and_settle();

    // Random phases, each under its own register setting and load bias
    for (p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        write_reg(CFG_ACTIVE_WORKERS, CfgW'(act_tab[p]));
        write_reg(CFG_SLOTS_PER_WORKER, CfgW'(spw_tab[p]));
      end else begin
        if ($urandom_range(0, 3) != 0)
          write_reg(CFG_ACTIVE_WORKERS, CfgW'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) != 0)
          write_reg(CFG_SLOTS_PER_WORKER, CfgW'($urandom_range(0, 31)));
      end
      n_settings++;
      alloc_pct = pct_tab[$urandom_range(0, 3)];
      for (i = 0; i < PHASE_ITEMS; i++) begin
        while (pending_reqs.size() >= 2) @(posedge clk_i);
        push_random_req(alloc_pct);
      end
      drain_and_settle();
    end

    $display("checked %0d results under %0d register settings",
             n_granted + n_released + n_full + n_free_rel, n_settings);
    $display("  grants %0d, releases %0d, all-full %0d, releases of free slots %0d",
             n_granted, n_released, n_full, n_free_rel);
    if (mismatches == 0) begin
      $display("** least_busy_slot_allocator: PASSED **");
    end else begin
      $display("** least_busy_slot_allocator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lbsa_pkg.sv
hw/rtl/lbsa_ctrl.sv
hw/rtl/lbsa_dp.sv
hw/rtl/least_busy_slot_allocator.sv
tb/sv/tb.sv
